@@ hdl/ioir_pkg.sv @@
// ----------------------------------------------------------------------------
// ioir_pkg
// Shared types and constants of the I/O interrupt redirector.
// ----------------------------------------------------------------------------
package ioir_pkg;

  // Table sizes.
  localparam int NUM_REDIRECTS   = 24;
  localparam int MAX_LOCAL_APICS = 16;
  localparam int RT_AW = (NUM_REDIRECTS > 1) ? $clog2(NUM_REDIRECTS) : 1;
  localparam int LA_AW = (MAX_LOCAL_APICS > 1) ? $clog2(MAX_LOCAL_APICS) : 1;

  // Bus windows and indirect register map.
  localparam logic [7:0] WIN_SELECT  = 8'h00;
  localparam logic [7:0] WIN_DATA    = 8'h10;
  localparam logic [7:0] REG_ID      = 8'h00;
  localparam logic [7:0] REG_VERSION = 8'h01;
  localparam logic [7:0] REG_ARB     = 8'h02;
  localparam int         TABLE_BASE  = 16;
  localparam int         TABLE_END   = TABLE_BASE + 2 * NUM_REDIRECTS;
  localparam logic [31:0] VERSION_WORD = 32'(((NUM_REDIRECTS - 1) << 16) | 32'h11);
  localparam logic [3:0] FLAT_MODEL  = 4'hf;

  // Operation codes.
  localparam logic [2:0] MODE_READ   = 3'd0;
  localparam logic [2:0] MODE_WRITE  = 3'd1;
  localparam logic [2:0] MODE_IRQ    = 3'd2;
  localparam logic [2:0] MODE_REG    = 3'd3;
  localparam logic [2:0] MODE_UPDATE = 3'd4;

  // Result status codes.
  localparam logic [2:0] STAT_OK            = 3'd0;
  localparam logic [2:0] STAT_RANGE         = 3'd1;
  localparam logic [2:0] STAT_EXISTS        = 3'd2;
  localparam logic [2:0] STAT_NOT_FOUND     = 3'd3;
  localparam logic [2:0] STAT_NOT_SUPPORTED = 3'd4;
  localparam logic [2:0] STAT_INVALID       = 3'd5;

  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  bus_offset;
    logic [31:0] write_data;
    logic [7:0]  irq_number;
    logic [7:0]  apic_index;
    logic [7:0]  logical_id;
    logic [3:0]  dest_format;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] read_data;
    logic [7:0]  vector;
    logic [7:0]  target_apic;
    logic        deliver;
  } rsp_t;

endpackage

@@ hdl/io_interrupt_redirector.sv @@
// ----------------------------------------------------------------------------
// io_interrupt_redirector
// Indirect-register I/O interrupt redirector with a local APIC table.
// ----------------------------------------------------------------------------
// Each request item gives exactly one response item. Bus reads and writes,
// interrupts in physical destination mode and local APIC registration or
// update go from acceptance to the response register by accepting the item
// and starting the table reads, executing against the read data, and then
// handing the result to the output register. An interrupt in logical
// destination mode scans the local APIC info memory one slot per cycle
// through its single read port between the execute and hand-off steps,
// stopping at the first match or at the last slot. The block handles one
// item at a time; a finished response may wait in the output register while
// the next request item is already being worked on. The redirection table
// and the APIC info live in synchronous RAMs whose entries read as zero
// until first written, tracked by per-entry valid flops, so no clearing pass
// follows reset.
// ----------------------------------------------------------------------------
module io_interrupt_redirector (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  ioir_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output ioir_pkg::rsp_t rsp
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state;

  // Architectural registers.
  logic [7:0]  select_reg;
  logic [31:0] apic_id;
  logic [ioir_pkg::NUM_REDIRECTS-1:0]   rt_valid;
  logic [ioir_pkg::MAX_LOCAL_APICS-1:0] present;
  logic [ioir_pkg::MAX_LOCAL_APICS-1:0] info_valid;

  // Working registers of the item in progress.
  ioir_pkg::req_t           item;
  ioir_pkg::rsp_t           res;
  logic [ioir_pkg::RT_AW-1:0] rt_addr;
  logic [7:0]               mda;
  logic [7:0]               vec;
  logic [ioir_pkg::LA_AW-1:0] scan_idx;

  // Memory ports.
  logic                       rt_we;
  logic [63:0]                rt_wdata;
  logic [ioir_pkg::RT_AW-1:0] rt_raddr;
  logic [63:0]                rt_rdata;
  logic                       info_we;
  logic [ioir_pkg::LA_AW-1:0] info_raddr;
  logic [11:0]                info_rdata;

  // Decode and execute signals.
  logic                       sel_is_table;
  logic [ioir_pkg::RT_AW-1:0] sel_entry;
  logic [63:0]                rt_word;
  logic [31:0]                lower;
  logic [31:0]                upper;
  logic [3:0]                 dest;
  logic                       dest_ok;
  logic                       idx_ok;
  logic [ioir_pkg::LA_AW-1:0] idx_la;
  ioir_pkg::rsp_t             exec_rsp;
  logic                       exec_scan;
  logic                       sel_wr;
  logic                       id_wr;
  logic                       present_set;
  logic [11:0]                info_word;
  logic                       scan_hit;
  logic                       scan_last;
  ioir_pkg::rsp_t             scan_rsp;

  assign req_stall = (state != S_IDLE);

  // The select register picks a table half when it lies in the table window;
  // entry is the offset halved and the low bit chooses the upper half.
  assign sel_is_table = (32'(select_reg) >= ioir_pkg::TABLE_BASE) &&
                        (32'(select_reg) < ioir_pkg::TABLE_END);
  assign sel_entry = ioir_pkg::RT_AW'((select_reg - 8'(ioir_pkg::TABLE_BASE)) >> 1);

  // The redirection table is read on the accepting edge, so the entry is
  // ready in the execute cycle.
  assign rt_raddr = (req.mode == ioir_pkg::MODE_IRQ) ?
                    req.irq_number[ioir_pkg::RT_AW-1:0] : sel_entry;

  assign rt_word = rt_valid[rt_addr] ? rt_rdata : 64'd0;
  assign lower   = rt_word[31:0];
  assign upper   = rt_word[63:32];
  assign dest    = upper[27:24];
  assign dest_ok = (32'(dest) < ioir_pkg::MAX_LOCAL_APICS) &&
                   present[ioir_pkg::LA_AW'(32'(dest))];
  assign idx_ok  = 32'(item.apic_index) < ioir_pkg::MAX_LOCAL_APICS;
  assign idx_la  = ioir_pkg::LA_AW'(32'(item.apic_index));

  assign rt_wdata = select_reg[0] ? {item.write_data, rt_word[31:0]}
                                  : {rt_word[63:32], item.write_data};

  // Execute one item against the data read from the redirection table.
  always_comb begin
    exec_rsp        = '0;
    exec_rsp.status = ioir_pkg::STAT_NOT_SUPPORTED;
    exec_scan       = 1'b0;
    sel_wr          = 1'b0;
    id_wr           = 1'b0;
    rt_we           = 1'b0;
    present_set     = 1'b0;
    info_we         = 1'b0;
    if (state == S_EXEC) begin
      case (item.mode)
        ioir_pkg::MODE_READ: begin
          if (item.bus_offset == ioir_pkg::WIN_SELECT) begin
            exec_rsp.read_data = {24'd0, select_reg};
            exec_rsp.status    = ioir_pkg::STAT_OK;
          end else if (item.bus_offset == ioir_pkg::WIN_DATA) begin
            if (select_reg == ioir_pkg::REG_ID) begin
              exec_rsp.read_data = apic_id;
              exec_rsp.status    = ioir_pkg::STAT_OK;
            end else if (select_reg == ioir_pkg::REG_VERSION) begin
              exec_rsp.read_data = ioir_pkg::VERSION_WORD;
              exec_rsp.status    = ioir_pkg::STAT_OK;
            end else if (select_reg == ioir_pkg::REG_ARB) begin
              exec_rsp.status = ioir_pkg::STAT_OK;
            end else if (sel_is_table) begin
              exec_rsp.read_data = select_reg[0] ? upper : lower;
              exec_rsp.status    = ioir_pkg::STAT_OK;
            end
          end
        end
        ioir_pkg::MODE_WRITE: begin
          if (item.bus_offset == ioir_pkg::WIN_SELECT) begin
            if (item.write_data[31:8] != 24'd0) begin
              exec_rsp.status = ioir_pkg::STAT_INVALID;
            end else begin
              sel_wr          = 1'b1;
              exec_rsp.status = ioir_pkg::STAT_OK;
            end
          end else if (item.bus_offset == ioir_pkg::WIN_DATA) begin
            if (select_reg == ioir_pkg::REG_ID) begin
              id_wr           = 1'b1;
              exec_rsp.status = ioir_pkg::STAT_OK;
            end else if (select_reg == ioir_pkg::REG_VERSION ||
                         select_reg == ioir_pkg::REG_ARB) begin
              exec_rsp.status = ioir_pkg::STAT_OK;
            end else if (sel_is_table) begin
              rt_we           = 1'b1;
              exec_rsp.status = ioir_pkg::STAT_OK;
            end
          end
        end
        ioir_pkg::MODE_IRQ: begin
          if (32'(item.irq_number) >= ioir_pkg::NUM_REDIRECTS) begin
            exec_rsp.status = ioir_pkg::STAT_RANGE;
          end else if (!lower[11]) begin
            if (dest_ok) begin
              exec_rsp.status      = ioir_pkg::STAT_OK;
              exec_rsp.vector      = lower[7:0];
              exec_rsp.target_apic = {4'd0, dest};
              exec_rsp.deliver     = 1'b1;
            end else begin
              exec_rsp.status = ioir_pkg::STAT_NOT_FOUND;
            end
          end else begin
            exec_scan = 1'b1;
          end
        end
        ioir_pkg::MODE_REG: begin
          if (!idx_ok) begin
            exec_rsp.status = ioir_pkg::STAT_RANGE;
          end else if (present[idx_la]) begin
            exec_rsp.status = ioir_pkg::STAT_EXISTS;
          end else begin
            present_set     = 1'b1;
            exec_rsp.status = ioir_pkg::STAT_OK;
          end
        end
        ioir_pkg::MODE_UPDATE: begin
          if (!idx_ok) begin
            exec_rsp.status = ioir_pkg::STAT_RANGE;
          end else begin
            info_we         = 1'b1;
            exec_rsp.status = ioir_pkg::STAT_OK;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Logical-mode scan: the info memory is read one slot ahead, slot zero
  // during the execute cycle and the next slot during each scan cycle.
  assign info_raddr = (state == S_SCAN) ? scan_idx + ioir_pkg::LA_AW'(1)
                                        : '0;
  assign info_word  = info_valid[scan_idx] ? info_rdata : 12'd0;
  assign scan_hit   = present[scan_idx] && ((info_word[7:0] & mda) != 8'd0);
  assign scan_last  = 32'(scan_idx) == ioir_pkg::MAX_LOCAL_APICS - 1;

  always_comb begin
    scan_rsp        = '0;
    scan_rsp.status = ioir_pkg::STAT_NOT_FOUND;
    if (scan_hit) begin
      if (info_word[11:8] == ioir_pkg::FLAT_MODEL) begin
        scan_rsp.status      = ioir_pkg::STAT_OK;
        scan_rsp.vector      = vec;
        scan_rsp.target_apic = 8'(scan_idx);
        scan_rsp.deliver     = 1'b1;
      end else begin
        scan_rsp.status = ioir_pkg::STAT_NOT_SUPPORTED;
      end
    end
  end

  // Accesses to one entry never overlap: every write happens in the execute
  // cycle and the next item is read only after the current one is done.
  ioir_ram #(.WIDTH(64), .DEPTH(ioir_pkg::NUM_REDIRECTS)) u_rt_ram (
    .clk   (clk),
    .we    (rt_we),
    .waddr (rt_addr),
    .wdata (rt_wdata),
    .raddr (rt_raddr),
    .rdata (rt_rdata)
  );

  ioir_ram #(.WIDTH(12), .DEPTH(ioir_pkg::MAX_LOCAL_APICS)) u_info_ram (
    .clk   (clk),
    .we    (info_we),
    .waddr (idx_la),
    .wdata ({item.dest_format, item.logical_id}),
    .raddr (info_raddr),
    .rdata (info_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rsp_valid  <= 1'b0;
      select_reg <= 8'd0;
      apic_id    <= 32'd0;
      rt_valid   <= '0;
      present    <= '0;
      info_valid <= '0;
    end else begin
      // In the done state the output register is refilled instead.
      if (rsp_valid && !rsp_stall && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            item    <= req;
            rt_addr <= rt_raddr;
            state   <= S_EXEC;
          end
        end
        S_EXEC: begin
          res      <= exec_rsp;
          mda      <= upper[31:24];
          vec      <= lower[7:0];
          scan_idx <= '0;
          if (sel_wr) begin
            select_reg <= item.write_data[7:0];
          end
          if (id_wr) begin
            apic_id <= item.write_data;
          end
          if (rt_we) begin
            rt_valid[rt_addr] <= 1'b1;
          end
          if (present_set) begin
            present[idx_la] <= 1'b1;
          end
          if (info_we) begin
            info_valid[idx_la] <= 1'b1;
          end
          state <= exec_scan ? S_SCAN : S_DONE;
        end
        S_SCAN: begin
          if (scan_hit || scan_last) begin
            res   <= scan_rsp;
            state <= S_DONE;
          end else begin
            scan_idx <= scan_idx + ioir_pkg::LA_AW'(1);
          end
        end
        S_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp       <= res;
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // An accepted item always moves straight into its execute cycle.
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> state == S_EXEC)
    else $error("accepted item did not enter execute");

  // A delivered interrupt always carries an ok status.
  a_deliver_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.deliver |-> rsp.status == ioir_pkg::STAT_OK)
    else $error("delivery with failing status");

  // Without delivery the vector and target fields stay zero.
  a_nodeliver_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.deliver |-> rsp.vector == 8'd0 && rsp.target_apic == 8'd0)
    else $error("vector or target set without delivery");

  // Read data is nonzero only on a successful access.
  a_rdata_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.read_data != 32'd0 |-> rsp.status == ioir_pkg::STAT_OK)
    else $error("read data returned with failing status");

  // The scan never walks past the last local APIC slot.
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> 32'(scan_idx) < ioir_pkg::MAX_LOCAL_APICS)
    else $error("local APIC scan out of range");

endmodule

@@ hdl/ioir_ram.sv @@
// ----------------------------------------------------------------------------
// ioir_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module ioir_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
